[rtl/cleb_pkg.sv]
// Shared types and constants for the cursor line-edit buffer.
package cleb_pkg;

  // Default text capacity in characters
  localparam int CAPACITY_DEF = 64;

  // Payload field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int AMT_W  = 16;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LEFT   = 2'd2,
    CMD_RIGHT  = 2'd3
  } cmd_t;

endpackage

[rtl/cleb_if.sv]
// Valid/ready channel interfaces for command and text beats.
interface cleb_in_if;
  import cleb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_in;
  logic              end_of_word;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, command, char_in, end_of_word, amount, input ready);
  modport sink   (input valid, command, char_in, end_of_word, amount, output ready);
endinterface

interface cleb_out_if;
  import cleb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_of_dump;
  logic              text_empty;
  logic              overflow_seen;

  modport source (output valid, char_out, last_of_dump, text_empty, overflow_seen,
                  input ready);
  modport sink   (input valid, char_out, last_of_dump, text_empty, overflow_seen,
                  output ready);
endinterface

[rtl/cleb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cursor_line_edit_buffer.sv]
// Top level: line-edit buffer with a cursor, text held in one RAM.
//
// in_if carries one command per beat: insert a character, delete to the
// left of the cursor, or move the cursor left or right by amount (clamped).
// out_if carries the text dump: one beat per character, left to right,
// last_of_dump on the final beat, or a single text_empty beat for no text.
// A dump follows every delete or move and every insert with end_of_word.
//
// Commands are handled one at a time; in_if.ready is high only when idle.
// An insert at the end of the text writes the character directly; elsewhere
// it first shifts the text from the end down to the cursor up one place to
// open a slot. A delete that moves text shifts it from the cursor to the end
// down by the deleted count; a move touches no RAM. A dump first reads
// address 0, then sends its beats. Shifts go one character at a time
// through the single RAM read and write port.
// An insert into a full buffer is dropped; overflow_seen reports it on the
// next dump. A stalled receiver holds the current beat; the RAM read
// address stays put until the beat is taken.
// Reset empties the text and puts the cursor at 0; RAM contents are not
// cleared, only entries below the length are ever read.
module cursor_line_edit_buffer #(
  parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  cleb_in_if.sink  in_if,
  cleb_out_if.source out_if
);
  import cleb_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SHIFT  = 5'b00010,
    ST_PUT    = 5'b00100,
    ST_DSTART = 5'b01000,
    ST_DUMP   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic              drop_r, drop_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              eow_r, eow_nxt;
  logic [LW-1:0]     del_n_r, del_n_nxt;
  logic              is_ins_r, is_ins_nxt;
  logic [AW-1:0]     sh_rd_r, sh_rd_nxt;
  logic              reading_r, reading_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic              in_fire, out_fire;
  logic [AMT_W-1:0]  cur_ext;
  logic [LW-1:0]     del_n;
  logic [LW-1:0]     left_cur;
  logic [AMT_W:0]    right_sum;
  logic [LW-1:0]     right_cur;
  logic [AW-1:0]     sh_stop;
  logic              empty, last;

  cleb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshakes
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;

  // cursor arithmetic, clamped
  assign cur_ext   = AMT_W'(cur_r);
  assign del_n     = (in_if.amount < cur_ext) ? LW'(in_if.amount) : cur_r;
  assign left_cur  = (cur_ext > in_if.amount) ? LW'(cur_ext - in_if.amount) : '0;
  assign right_sum = {1'b0, in_if.amount} + (AMT_W + 1)'(cur_r);
  assign right_cur = (right_sum < (AMT_W + 1)'(len_r)) ? LW'(right_sum) : len_r;

  // last read address of a shift: insert walks down to the cursor,
  // delete walks up to the end of the text
  assign sh_stop = is_ins_r ? AW'(cur_r) : AW'(len_r - LW'(1));

  // dump beat
  assign empty = (len_r == '0);
  assign last  = empty || (LW'(idx_r) == len_r - LW'(1));

  assign out_if.valid         = (state_r == ST_DUMP);
  assign out_if.char_out      = empty ? '0 : ram_rdata;
  assign out_if.last_of_dump  = last;
  assign out_if.text_empty    = empty;
  assign out_if.overflow_seen = drop_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    drop_nxt      = drop_r;
    ch_nxt        = ch_r;
    eow_nxt       = eow_r;
    del_n_nxt     = del_n_r;
    is_ins_nxt    = is_ins_r;
    sh_rd_nxt     = sh_rd_r;
    reading_nxt   = reading_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    idx_nxt       = idx_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ch_nxt  = in_if.char_in;
          eow_nxt = in_if.end_of_word;
          case (in_if.command)
            CMD_INSERT: begin
              if (len_r == LW'(CAPACITY)) begin
                drop_nxt = 1'b1;
                if (in_if.end_of_word) begin
                  state_nxt = ST_DSTART;
                end
              end else if (cur_r == len_r) begin
                state_nxt = ST_PUT;
              end else begin
                is_ins_nxt  = 1'b1;
                sh_rd_nxt   = AW'(len_r - LW'(1));
                reading_nxt = 1'b1;
                pend_nxt    = 1'b0;
                state_nxt   = ST_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (del_n == '0 || cur_r == len_r) begin
                len_nxt   = len_r - del_n;
                cur_nxt   = cur_r - del_n;
                state_nxt = ST_DSTART;
              end else begin
                is_ins_nxt  = 1'b0;
                del_n_nxt   = del_n;
                sh_rd_nxt   = AW'(cur_r);
                reading_nxt = 1'b1;
                pend_nxt    = 1'b0;
                state_nxt   = ST_SHIFT;
              end
            end
            CMD_LEFT: begin
              cur_nxt   = left_cur;
              state_nxt = ST_DSTART;
            end
            default: begin
              cur_nxt   = right_cur;
              state_nxt = ST_DSTART;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // write back the character read last cycle, one place up for an insert or del_n_r places down for a delete
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = is_ins_r ? (pend_addr_r + AW'(1)) : (pend_addr_r - AW'(del_n_r));
          ram_wdata = ram_rdata;
        end
        if (reading_r) begin
          ram_raddr     = sh_rd_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = sh_rd_r;
          if (sh_rd_r == sh_stop) begin
            reading_nxt = 1'b0;
          end else if (is_ins_r) begin
            sh_rd_nxt = sh_rd_r - AW'(1);
          end else begin
            sh_rd_nxt = sh_rd_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (is_ins_r) begin
            state_nxt = ST_PUT;
          end else begin
            len_nxt   = len_r - del_n_r;
            cur_nxt   = cur_r - del_n_r;
            state_nxt = ST_DSTART;
          end
        end
      end

      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur_r);
        ram_wdata = ch_r;
        len_nxt   = len_r + LW'(1);
        cur_nxt   = cur_r + LW'(1);
        state_nxt = eow_r ? ST_DSTART : ST_IDLE;
      end

      ST_DSTART: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        state_nxt = ST_DUMP;
      end

      ST_DUMP: begin
        if (out_fire) begin
          if (last) begin
            drop_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        // read ahead so the next beat is ready when this one is taken
        ram_raddr = idx_nxt;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      len_r     <= '0;
      cur_r     <= '0;
      drop_r    <= 1'b0;
      reading_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      cur_r     <= cur_nxt;
      drop_r    <= drop_nxt;
      reading_r <= reading_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    eow_r       <= eow_nxt;
    del_n_r     <= del_n_nxt;
    is_ins_r    <= is_ins_nxt;
    sh_rd_r     <= sh_rd_nxt;
    pend_addr_r <= pend_addr_nxt;
    idx_r       <= idx_nxt;
  end

endmodule

[rtl/cleb_checker.sv]
// Port-level checks for the line-edit buffer, bound to the top level.
module cleb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [cleb_pkg::CMD_W-1:0]   in_command,
  input logic                         in_end_of_word,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_last_of_dump,
  input logic                         out_text_empty,
  input logic                         out_overflow_seen
);
  import cleb_pkg::*;

  // no command is taken while a dump is under way
  a_busy_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("command accepted during a dump");

  // an empty text is reported as a single beat
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_empty |-> out_last_of_dump)
    else $error("empty-text beat not marked last");

  // the overflow flag is the same on every beat of one dump
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_dump |=>
      out_valid && !out_text_empty && (out_overflow_seen == $past(out_overflow_seen)))
    else $error("dump flags changed mid-dump");

  // an insert without end of word gives no text
  a_quiet_insert: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_INSERT) && !in_end_of_word |=> !out_valid)
    else $error("dump after an unflagged insert");

endmodule

bind cursor_line_edit_buffer cleb_checker u_cleb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .in_command        (in_if.command),
  .in_end_of_word    (in_if.end_of_word),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_last_of_dump  (out_if.last_of_dump),
  .out_text_empty    (out_if.text_empty),
  .out_overflow_seen (out_if.overflow_seen)
);
